/* hdl/assert_macros.svh */
// Assertion macros shared by the integer to radix digit converter.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/i2rd_pkg.sv */
// Package for the integer to radix digit converter: types, constants, char mapping.
// No dependencies; used by i2rd_cell, int_to_radix_digits, i2rd_checker and tb_top.
package i2rd_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int RADIX_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_GAP  = 7'd7;
    localparam logic [DIGIT_W-1:0] DECIMAL_TOP = 6'd9;

    // Per-cycle command to every cell of the row
    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } cell_ctl_t;

    // Conversion wave handed from one cell to the next
    typedef struct packed {
        logic act;
        logic carry;
    } cell_link_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Digit value to ASCII: 0..9 -> '0'..'9', 10 and up -> 'A' onward
    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] t;
        t = {1'b0, d};
        if (d > DECIMAL_TOP)
        begin
            t = t + LETTER_GAP;
        end
        return t + ASCII_ZERO;
    endfunction

    // Clamp a written radix into 2..36
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        c = r;
        if (r < RADIX_MIN)
        begin
            c = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            c = RADIX_MAX;
        end
        return c;
    endfunction

endpackage

/* hdl/i2rd_cell.sv */
// One digit cell of the converter row: holds one radix digit and a carry.
// Depends on i2rd_pkg. Clears, doubles-and-adds on the passing wave, or shifts up.
module i2rd_cell
    import i2rd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [RADIX_W-1:0] radix,
    input  cell_link_t         link_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output cell_link_t         link_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    cell_link_t         link_reg, link_next;
    logic [DIGIT_W:0]   dbl;
    logic [DIGIT_W:0]   dbl_red;
    logic               over;

    // Double the digit and add the incoming carry; reduce once by the radix
    assign dbl     = {digit_reg, 1'b0} + {{DIGIT_W{1'b0}}, link_in.carry};
    assign over    = (dbl >= {1'b0, radix});
    assign dbl_red = dbl - {1'b0, radix};

    always_comb
    begin
        digit_next = digit_reg;
        link_next  = '0;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.convert)
        begin
            if (link_in.act)
            begin
                digit_next     = over ? dbl_red[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
                link_next.act  = 1'b1;
                link_next.carry = over;
            end
        end
        else if (ctl.shift)
        begin
            digit_next = digit_in;
        end
    end

    // Wave state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    // Digit payload
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign link_out = link_reg;
    assign digit    = digit_reg;

endmodule

/* hdl/int_to_radix_digits.sv */
// Integer to radix 2..36 ASCII digits, most significant character first.
// Sequence: the input bits cross the cell row as a wave, leading zero cells are skipped,
// then the characters are loaded into the output register. A new value is taken only when
// idle: input stalls from transfer until the last character is loaded.
// Reset: radix 10, idle, output register empty.
module int_to_radix_digits
    import i2rd_pkg::*;
#(
    parameter int VALUE_WIDTH       = 31,
    parameter int DIGIT_STACK_DEPTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   radix_wr_en,
    input  logic [RADIX_W-1:0]     radix_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last_digit
);

`include "assert_macros.svh"

    localparam int N          = DIGIT_STACK_DEPTH;
    localparam int CONV_LAST  = VALUE_WIDTH + DIGIT_STACK_DEPTH - 1;
    localparam int CNT_W      = $clog2(CONV_LAST + 1);
    localparam int REM_W      = $clog2(DIGIT_STACK_DEPTH + 1);

    state_t                   state_reg, state_next;
    logic [RADIX_W-1:0]       radix_reg;
    logic [VALUE_WIDTH-1:0]   value_sr_reg, value_sr_next;
    logic [CNT_W-1:0]         conv_cnt_reg, conv_cnt_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]        digit_char_reg, digit_char_next;
    logic                     last_digit_reg, last_digit_next;

    cell_ctl_t                ctl;
    cell_link_t               link [0:N];
    logic [DIGIT_W-1:0]       digit [0:N-1];
    logic [DIGIT_W-1:0]       top_digit;
    logic                     accept;
    logic                     out_load;
    logic                     skip_cond;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign top_digit = digit[N-1];
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign skip_cond = !ovf_reg && (top_digit == '0) && (rem_reg > REM_W'(1));

    // Radix register, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= clamp_radix(radix_wr_data);
        end
    end

    // Feed of the row: input bits MSB first while the wave is entering
    assign link[0].act   = (state_reg == ST_CONV) && (conv_cnt_reg < CNT_W'(VALUE_WIDTH));
    assign link[0].carry = value_sr_reg[VALUE_WIDTH-1];

    // Row commands
    always_comb
    begin
        ctl         = '0;
        ctl.clear   = accept;
        ctl.convert = (state_reg == ST_CONV);
        ctl.shift   = ((state_reg == ST_SKIP) && skip_cond) || out_load;
    end

    // Row of digit cells, least significant digit in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [DIGIT_W-1:0] shift_in;
            if (gi == 0)
            begin : g_first
                assign shift_in = '0;
            end
            else
            begin : g_rest
                assign shift_in = digit[gi-1];
            end
            i2rd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .radix    (radix_reg),
                .link_in  (link[gi]),
                .digit_in (shift_in),
                .link_out (link[gi+1]),
                .digit    (digit[gi])
            );
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        value_sr_next   = value_sr_reg;
        conv_cnt_next   = conv_cnt_reg;
        rem_next        = rem_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && out_stall;
        digit_char_next = digit_char_reg;
        last_digit_next = last_digit_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_CONV;
                    value_sr_next = value;
                    conv_cnt_next = '0;
                    rem_next      = REM_W'(N);
                    ovf_next      = 1'b0;
                end
            end
            ST_CONV:
            begin
                value_sr_next = {value_sr_reg[VALUE_WIDTH-2:0], 1'b0};
                conv_cnt_next = conv_cnt_reg + CNT_W'(1);
                // carry out of the top cell means more digits than cells
                ovf_next      = ovf_reg || link[N].carry;
                if (conv_cnt_reg == CNT_W'(CONV_LAST))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (skip_cond)
                begin
                    rem_next = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = char_of(top_digit);
                    last_digit_next = (rem_reg == REM_W'(1));
                    rem_next        = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conv_cnt_reg  <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_sr_reg   <= value_sr_next;
        digit_char_reg <= digit_char_next;
        last_digit_reg <= last_digit_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

    // Checks
    `ASSERT_IMP(a_wave_gone, state_reg == ST_SKIP || state_reg == ST_EMIT,
                !link[N].act, "conversion wave still in the row while reading digits")
    `ASSERT_IMP(a_digit_range, state_reg == ST_EMIT, top_digit < radix_reg,
                "top digit not below the radix")
    `ASSERT_IMP(a_rem_nonzero, state_reg == ST_SKIP || state_reg == ST_EMIT,
                rem_reg != '0, "no characters left while skipping or emitting")
    `ASSERT_NXT(a_last_to_idle, out_load && rem_reg == REM_W'(1),
                state_reg == ST_IDLE && last_digit_reg, "final character did not end the item")

endmodule

/* tb/i2rd_checker.sv */
// Checker for int_to_radix_digits: watches the radix port and both transfer channels.
// Predicts the character string of every accepted value and compares it against the output.
// Depends on i2rd_pkg for port widths and the radix and character constants.
`timescale 1ns / 1ps

module i2rd_checker
    import i2rd_pkg::*;
#(
    parameter int VALUE_WIDTH = 31,
    parameter int STACK_DEPTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   radix_wr_en,
    input  logic [RADIX_W-1:0]     radix_wr_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [CHAR_W-1:0]      digit_char,
    input  logic                   last_digit,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } digit_exp_t;

    // Characters still owed by the block, oldest first
    digit_exp_t         chars_due[$];
    digit_exp_t         oldest;
    logic [RADIX_W-1:0] radix_shadow;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        radix_shadow = RADIX_RESET;
    end

    // Out-of-range radix settings saturate to the nearest legal base
    function automatic longint unsigned base_of(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
        begin
            return 64'(RADIX_MIN);
        end
        if (r > RADIX_MAX)
        begin
            return 64'(RADIX_MAX);
        end
        return 64'(r);
    endfunction

    // Digit value to its ASCII character, letters after nine
    function automatic logic [CHAR_W-1:0] ascii_of(input int d);
        int c;
        c = d + int'(ASCII_ZERO);
        if (d > int'(DECIMAL_TOP))
        begin
            c = c + int'(LETTER_GAP);
        end
        return c[CHAR_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < 30)
        begin
            $display("%0t MISMATCH: %s", $time, what);
        end
        fail_count = fail_count + 1;
    endtask

    // Repeated division; remainders stored least significant first, then queued reversed
    task automatic queue_digits(input logic [VALUE_WIDTH-1:0] v);
        longint unsigned q;
        longint unsigned base;
        int              rems[$];
        digit_exp_t      e;
        base = base_of(radix_shadow);
        q    = 64'(v);
        if (q == 0)
        begin
            rems.push_back(0);
        end
        while (q != 0)
        begin
            // a full stack drops the more significant digits
            if (rems.size() < STACK_DEPTH)
            begin
                rems.push_back(int'(q % base));
            end
            q = q / base;
        end
        for (int i = rems.size() - 1; i >= 0; i--)
        begin
            e.ch      = ascii_of(rems[i]);
            e.is_last = (i == 0);
            chars_due.push_back(e);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (chars_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char 0x%0h last %0b",
                                              digit_char, last_digit));
                end
                else
                begin
                    oldest = chars_due.pop_front();
                    if (digit_char !== oldest.ch)
                    begin
                        report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h",
                                                  digit_char, oldest.ch));
                    end
                    if (last_digit !== oldest.is_last)
                    begin
                        report_mismatch($sformatf("last_digit %0b, want %0b",
                                                  last_digit, oldest.is_last));
                    end
                end
            end
            // input transfer uses the radix in force before any write this edge
            if (in_valid && !in_stall)
            begin
                queue_digits(value);
            end
            if (radix_wr_en)
            begin
                radix_shadow = radix_wr_data;
            end
        end
        pending <= chars_due.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the int_to_radix_digits testbench: clock, reset, radix writes and stimulus.
// Instantiates the block and i2rd_checker; relies on i2rd_pkg for widths and constants.
`timescale 1ns / 1ps

module tb_top;
    import i2rd_pkg::*;

    localparam int VALUE_WIDTH  = 31;
    localparam int STACK_DEPTH  = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int QUIET_LIMIT  = 4000;
    localparam int CHUNK_ITEMS  = 14;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   radix_wr_en   = 1'b0;
    logic [RADIX_W-1:0]     radix_wr_data = RADIX_RESET;
    logic                   in_valid      = 1'b0;
    logic [VALUE_WIDTH-1:0] value         = '0;
    logic                   out_stall     = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    logic [CHAR_W-1:0]      digit_char;
    logic                   last_digit;

    int   fail_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;

    int_to_radix_digits #(
        .VALUE_WIDTH       (VALUE_WIDTH),
        .DIGIT_STACK_DEPTH (STACK_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digit_char    (digit_char),
        .last_digit    (last_digit)
    );

    i2rd_checker #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix_wr_en   (radix_wr_en),
        .radix_wr_data (radix_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digit_char    (digit_char),
        .last_digit    (last_digit),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    // Receiver: one long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_taken)
        begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            hold_taken <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("int_to_radix_digits test failed");
            $finish;
        end
    end

    // Offer one value, with an optional random gap first; valid stays up afterwards
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Stop offering and wait until every owed character has been transferred
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        settle();
        radix_wr_en   <= 1'b1;
        radix_wr_data <= r;
        @(posedge clk);
        radix_wr_en <= 1'b0;
    endtask

    // Mix of full-width, narrowed, small and boundary values
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0, 1:    v = VALUE_WIDTH'($urandom());
            2:       v = VALUE_WIDTH'($urandom() >> $urandom_range(1, 30));
            3:       v = VALUE_WIDTH'($urandom_range(0, 40));
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = VALUE_WIDTH'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: decimal at the reset radix
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd9);
        send_value(31'd10);
        send_value(31'd1234567890);
        send_value(31'h7FFF_FFFF);
        // highest base, letters up to Z
        write_radix(6'd36);
        send_value(31'd35);
        send_value(31'd36);
        send_value(31'h7FFF_FFFF);
        // binary: longest strings
        write_radix(6'd2);
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'h7FFF_FFFF);
        send_value(31'h4000_0000);
        // radix settings outside 2..36 saturate
        write_radix(6'd0);
        send_value(31'd5);
        write_radix(6'd1);
        send_value(31'd6);
        write_radix(6'd37);
        send_value(31'd71);
        write_radix(6'd63);
        send_value(31'd35);
        write_radix(6'd16);
        send_value(31'hAB_CDEF);
        send_value(31'h2A5A_5A5A);

        // random: sender-light, then receiver-light, then no idling
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_radix(RADIX_W'($urandom_range(0, 63)));
            end
            else
            begin
                write_radix(RADIX_W'($urandom_range(2, 36)));
            end
            case (chunk / 2)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 87;
                end
                1:
                begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // back-pressure: receiver holds off while values keep coming
            if (chunk == 4)
            begin
                hold_go <= 1'b1;
            end
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                send_value(pick_value());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("int_to_radix_digits test passed");
        end
        else
        begin
            $display("int_to_radix_digits test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/i2rd_pkg.sv
hdl/i2rd_cell.sv
hdl/int_to_radix_digits.sv
tb/i2rd_checker.sv
tb/tb_top.sv
